/* src/tba_pkg.sv */
// Shared types, widths and constants of the tree bitmap identifier allocator.
package tba_pkg;

    // Widths of identifiers, counts and child indices.
    localparam int ID_W    = 10;
    localparam int CNT_W   = ID_W + 1;
    localparam int IDX_W   = ID_W + 2;
    localparam int MAX_IDS = 1024;
    localparam int FLAG_W  = 2;

    // Node flag layout: bit 0 used, bit 1 subtree full.
    localparam int USED_BIT = 0;
    localparam int FULL_BIT = 1;
    localparam logic [FLAG_W-1:0] FLAG_USED = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_FULL = 2'b10;
    localparam logic [FLAG_W-1:0] FLAG_BOTH = FLAG_USED | FLAG_FULL;

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    // Read address selection of the flag memory.
    typedef enum logic [2:0] {
        RA_ROOT,
        RA_ID,
        RA_LEFT,
        RA_RIGHT,
        RA_SIB,
        RA_PARENT
    } t_raddr;

    // Write operations on the flag memory and the counters.
    typedef enum logic [2:0] {
        WOP_NONE,
        WOP_MARK,
        WOP_GROW,
        WOP_UNUSE,
        WOP_PFULL,
        WOP_PCLR
    } t_wop;

    // Loads of the current node register.
    typedef enum logic [2:0] {
        NL_NONE,
        NL_ROOT,
        NL_LEFT,
        NL_RIGHT,
        NL_ID
    } t_nload;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REQ_ROOT,
        S_ROOT_CHK,
        S_WALK,
        S_LEFT_CHK,
        S_RIGHT_CHK,
        S_MARK,
        S_GROW,
        S_UP_SIB,
        S_UP_PAR,
        S_UP_WR,
        S_REL_RD,
        S_REL_CHK,
        S_REL_UP_RD,
        S_REL_UP_WR,
        S_QRY_RD,
        S_QRY_CHK,
        S_CLEAR,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    cap;
        logic    rd_en;
        t_raddr  raddr;
        t_wop    wop;
        t_nload  nload;
        logic    sib_lat;
        logic    clear_all;
        logic    set_status;
        t_status status;
        logic    set_used;
        logic    fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hw_zero;
        logic hw_max;
        logic id_in_range;
        logic id_zero;
        logic node_zero;
        logic left_exists;
        logic right_exists;
        logic sib_exists;
        logic parent_root;
        logic rd_used;
        logic rd_full;
        logic out_free;
    } t_sts;

endpackage

/* src/tba_dpath.sv */
// Datapath of the allocator: flag memory, node and counter registers, result register.
module tba_dpath import tba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [1:0]       i_op,
    input  logic [ID_W-1:0]  i_id,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [ID_W-1:0]  o_result_id,
    output logic [1:0]       o_status,
    output logic             o_is_used,
    output logic [CNT_W-1:0] o_allocated_count
);

    logic [FLAG_W-1:0] r_mem [MAX_IDS];

    t_op               r_op;
    logic [ID_W-1:0]   r_id;
    logic [ID_W-1:0]   r_node;
    logic [ID_W-1:0]   n_node;
    logic [FLAG_W-1:0] r_flags;
    logic [FLAG_W-1:0] n_flags;
    logic              r_sfull;
    logic [CNT_W-1:0]  r_hw;
    logic [CNT_W-1:0]  n_hw;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [FLAG_W-1:0] r_rd;
    logic [ID_W-1:0]   r_res_id;
    t_status           r_pend_status;
    logic              r_pend_used;
    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    t_status           r_out_status;
    logic              r_out_used;
    logic [CNT_W-1:0]  r_out_cnt;

    logic [IDX_W-1:0]  w_hw_x;
    logic [IDX_W-1:0]  w_node_x;
    logic [IDX_W-1:0]  w_left;
    logic [IDX_W-1:0]  w_right;
    logic [IDX_W-1:0]  w_sib;
    logic [ID_W-1:0]   w_node_m1;
    logic [ID_W-1:0]   w_parent;
    logic              w_node_full;
    logic [ID_W-1:0]   w_raddr;
    logic              w_we;
    logic [ID_W-1:0]   w_waddr;
    logic [FLAG_W-1:0] w_wdata;

    // Tree neighbours of the current node.
    assign w_hw_x    = IDX_W'(r_hw);
    assign w_node_x  = IDX_W'(r_node);
    assign w_left    = {w_node_x[IDX_W-2:0], 1'b1};
    assign w_right   = w_left + IDX_W'(1);
    assign w_sib     = r_node[0] ? (w_node_x + IDX_W'(1)) : (w_node_x - IDX_W'(1));
    assign w_node_m1 = r_node - ID_W'(1);
    assign w_parent  = {1'b0, w_node_m1[ID_W-1:1]};
    assign w_node_full = r_flags[USED_BIT] & r_flags[FULL_BIT];

    // Status towards the controller.
    always_comb begin
        o_sts.hw_zero      = (r_hw == '0);
        o_sts.hw_max       = (r_hw == CNT_W'(MAX_IDS));
        o_sts.id_in_range  = (CNT_W'(r_id) < r_hw);
        o_sts.id_zero      = (r_id == '0);
        o_sts.node_zero    = (r_node == '0);
        o_sts.left_exists  = (w_left < w_hw_x);
        o_sts.right_exists = (w_right < w_hw_x);
        o_sts.sib_exists   = (w_sib < w_hw_x);
        o_sts.parent_root  = (w_parent == '0);
        o_sts.rd_used      = r_rd[USED_BIT];
        o_sts.rd_full      = r_rd[FULL_BIT];
        o_sts.out_free     = !r_out_valid || i_ready;
    end

    // Read address selection.
    always_comb begin
        unique case (i_cmd.raddr)
            RA_ROOT:   w_raddr = '0;
            RA_ID:     w_raddr = r_id;
            RA_LEFT:   w_raddr = w_left[ID_W-1:0];
            RA_RIGHT:  w_raddr = w_right[ID_W-1:0];
            RA_SIB:    w_raddr = w_sib[ID_W-1:0];
            RA_PARENT: w_raddr = w_parent;
            default:   w_raddr = '0;
        endcase
    end

    // Write address and data for each write operation.
    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_node;
        w_wdata = r_flags;
        unique case (i_cmd.wop)
            WOP_NONE: begin
                w_we = 1'b0;
            end
            WOP_MARK: begin
                w_wdata = r_flags | FLAG_USED;
            end
            WOP_GROW: begin
                w_waddr = r_hw[ID_W-1:0];
                w_wdata = FLAG_BOTH;
            end
            WOP_UNUSE: begin
                w_waddr = r_id;
                w_wdata = r_rd & ~FLAG_USED;
            end
            WOP_PFULL: begin
                w_waddr = w_parent;
                w_wdata = {w_node_full & r_sfull, r_rd[USED_BIT]};
            end
            WOP_PCLR: begin
                w_waddr = w_parent;
                w_wdata = r_rd & ~FLAG_FULL;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Flag memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    // Next value of the current node and its flags.
    always_comb begin
        n_node  = r_node;
        n_flags = r_flags;
        unique case (i_cmd.nload)
            NL_NONE: begin
            end
            NL_ROOT: begin
                n_node  = '0;
                n_flags = r_rd;
            end
            NL_LEFT: begin
                n_node  = w_left[ID_W-1:0];
                n_flags = r_rd;
            end
            NL_RIGHT: begin
                n_node  = w_right[ID_W-1:0];
                n_flags = r_rd;
            end
            NL_ID: begin
                n_node  = r_id;
                n_flags = r_rd;
            end
            default: begin
            end
        endcase
        unique case (i_cmd.wop)
            WOP_MARK: begin
                n_flags = w_wdata;
            end
            WOP_GROW: begin
                n_node  = r_hw[ID_W-1:0];
                n_flags = w_wdata;
            end
            WOP_PFULL, WOP_PCLR: begin
                n_node  = w_parent;
                n_flags = w_wdata;
            end
            default: begin
            end
        endcase
    end

    // Next high-water mark and allocated count.
    always_comb begin
        n_hw  = r_hw;
        n_cnt = r_cnt;
        if (i_cmd.clear_all) begin
            n_hw  = '0;
            n_cnt = '0;
        end else begin
            unique case (i_cmd.wop)
                WOP_MARK: begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                WOP_GROW: begin
                    n_hw  = r_hw + CNT_W'(1);
                    n_cnt = r_cnt + CNT_W'(1);
                end
                WOP_UNUSE: begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Control state: counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw        <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hw  <= n_hw;
            r_cnt <= n_cnt;
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_flags <= n_flags;
        if (i_cmd.sib_lat) begin
            r_sfull <= !o_sts.sib_exists || (r_rd[USED_BIT] & r_rd[FULL_BIT]);
        end
        if (i_cmd.cap) begin
            r_op          <= t_op'(i_op);
            r_id          <= i_id;
            r_res_id      <= i_id;
            r_pend_status <= ST_OK;
            r_pend_used   <= 1'b0;
        end else begin
            if (i_cmd.wop == WOP_MARK) begin
                r_res_id <= r_node;
            end else if (i_cmd.wop == WOP_GROW) begin
                r_res_id <= r_hw[ID_W-1:0];
            end
            if (i_cmd.set_status) begin
                r_pend_status <= i_cmd.status;
            end
            if (i_cmd.set_used) begin
                r_pend_used <= r_rd[USED_BIT];
            end
        end
    end

    // Result register: a finished beat waits here while the next item starts.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_id     <= r_res_id;
            r_out_status <= r_pend_status;
            r_out_used   <= r_pend_used;
            r_out_cnt    <= r_cnt;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_id       = r_out_id;
    assign o_status          = r_out_status;
    assign o_is_used         = (r_op == OP_QUERY) ? r_out_used : r_out_used;
    assign o_allocated_count = r_out_cnt;

endmodule

/* src/tba_ctrl.sv */
// Controller state machine of the allocator: sequences memory reads and writes per item.
module tba_ctrl import tba_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    input  t_sts       i_sts,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_left_elig;

    // A child is eligible when it is free or its subtree is not full.
    assign w_left_elig = !i_sts.rd_used || !i_sts.rd_full;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (t_op'(i_op))
                        OP_REQUEST: n_state = S_REQ_ROOT;
                        OP_RELEASE: n_state = S_REL_RD;
                        OP_QUERY:   n_state = S_QRY_RD;
                        OP_CLEAR:   n_state = S_CLEAR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_REQ_ROOT: begin
                n_state = i_sts.hw_zero ? S_GROW : S_ROOT_CHK;
            end
            S_ROOT_CHK: begin
                priority if (!i_sts.rd_used) begin
                    n_state = S_MARK;
                end else if (!i_sts.rd_full) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_GROW;
                end
            end
            S_WALK: begin
                priority if (i_sts.left_exists) begin
                    n_state = S_LEFT_CHK;
                end else if (i_sts.right_exists) begin
                    n_state = S_RIGHT_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LEFT_CHK: begin
                priority if (w_left_elig) begin
                    n_state = i_sts.rd_used ? S_WALK : S_MARK;
                end else if (i_sts.right_exists) begin
                    n_state = S_RIGHT_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RIGHT_CHK: begin
                priority if (w_left_elig) begin
                    n_state = i_sts.rd_used ? S_WALK : S_MARK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                // The root has no ancestors to refresh.
                n_state = i_sts.node_zero ? S_DONE : S_UP_SIB;
            end
            S_GROW: begin
                n_state = (i_sts.hw_max || i_sts.hw_zero) ? S_DONE : S_UP_SIB;
            end
            S_UP_SIB: begin
                n_state = S_UP_PAR;
            end
            S_UP_PAR: begin
                n_state = S_UP_WR;
            end
            S_UP_WR: begin
                n_state = i_sts.parent_root ? S_DONE : S_UP_SIB;
            end
            S_REL_RD: begin
                n_state = i_sts.id_in_range ? S_REL_CHK : S_DONE;
            end
            S_REL_CHK: begin
                n_state = (!i_sts.rd_used || i_sts.id_zero) ? S_DONE : S_REL_UP_RD;
            end
            S_REL_UP_RD: begin
                n_state = S_REL_UP_WR;
            end
            S_REL_UP_WR: begin
                n_state = i_sts.parent_root ? S_DONE : S_REL_UP_RD;
            end
            S_QRY_RD: begin
                n_state = i_sts.id_in_range ? S_QRY_CHK : S_DONE;
            end
            S_QRY_CHK: begin
                n_state = S_DONE;
            end
            S_CLEAR: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd           = '0;
        o_cmd.raddr     = RA_ROOT;
        o_cmd.wop       = WOP_NONE;
        o_cmd.nload     = NL_NONE;
        o_cmd.status    = ST_OK;
        o_ready         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.cap = i_valid;
            end
            S_REQ_ROOT: begin
                o_cmd.rd_en = !i_sts.hw_zero;
                o_cmd.raddr = RA_ROOT;
            end
            S_ROOT_CHK: begin
                o_cmd.nload = NL_ROOT;
            end
            S_WALK: begin
                priority if (i_sts.left_exists) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.raddr = RA_LEFT;
                end else if (i_sts.right_exists) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.raddr = RA_RIGHT;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                end
            end
            S_LEFT_CHK: begin
                priority if (w_left_elig) begin
                    o_cmd.nload = NL_LEFT;
                end else if (i_sts.right_exists) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.raddr = RA_RIGHT;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                end
            end
            S_RIGHT_CHK: begin
                priority if (w_left_elig) begin
                    o_cmd.nload = NL_RIGHT;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                end
            end
            S_MARK: begin
                o_cmd.wop = WOP_MARK;
            end
            S_GROW: begin
                if (i_sts.hw_max) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_FULL;
                end else begin
                    o_cmd.wop = WOP_GROW;
                end
            end
            S_UP_SIB: begin
                o_cmd.rd_en = i_sts.sib_exists;
                o_cmd.raddr = RA_SIB;
            end
            S_UP_PAR: begin
                o_cmd.sib_lat = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.raddr   = RA_PARENT;
            end
            S_UP_WR: begin
                o_cmd.wop = WOP_PFULL;
            end
            S_REL_RD: begin
                if (i_sts.id_in_range) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.raddr = RA_ID;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_USED;
                end
            end
            S_REL_CHK: begin
                if (i_sts.rd_used) begin
                    o_cmd.wop   = WOP_UNUSE;
                    o_cmd.nload = NL_ID;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_USED;
                end
            end
            S_REL_UP_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.raddr = RA_PARENT;
            end
            S_REL_UP_WR: begin
                o_cmd.wop = WOP_PCLR;
            end
            S_QRY_RD: begin
                if (i_sts.id_in_range) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.raddr = RA_ID;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_RANGE;
                end
            end
            S_QRY_CHK: begin
                o_cmd.set_used = 1'b1;
            end
            S_CLEAR: begin
                o_cmd.clear_all = 1'b1;
            end
            S_DONE: begin
                o_cmd.fin = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

/* src/tree_bitmap_id_allocator_core.sv */
// Top level of the tree bitmap identifier allocator: controller and datapath.
//
//  Channel  | Direction | Handshake          | Beat contents
//  ---------+-----------+--------------------+-------------------------------------------
//  input    | in        | i_valid / o_ready  | i_op, i_id
//  result   | out       | o_valid / i_ready  | o_result_id, o_status, o_is_used,
//           |           |                    | o_allocated_count
//
// Items are handled one at a time; the flag memory has one read and one write port with
// registered read data. A request walks down through the walk and child-check states and
// refreshes full flags on the way up through sibling read, parent read and parent write;
// a release clears full flags by parent read and write, and a clear resets the counters.
// Reset clears the counters, result valid and state only; flag memory needs no clearing.
// A result waiting on a stalled output does not stop the next item being accepted; that
// item then holds in its last cycle until the output register is free.
module tree_bitmap_id_allocator_core import tba_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_op,
    input  logic [ID_W-1:0]  i_id,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ID_W-1:0]  o_result_id,
    output logic [1:0]       o_status,
    output logic             o_is_used,
    output logic [CNT_W-1:0] o_allocated_count
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    tba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    // Flag memory, counters and result register.
    tba_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_op              (i_op),
        .i_id              (i_id),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_result_id       (o_result_id),
        .o_status          (o_status),
        .o_is_used         (o_is_used),
        .o_allocated_count (o_allocated_count)
    );

endmodule
